// ----- src/br8m_pkg.sv -----
// Shared types and the radix-8 Booth digit table for the multiplier core.
package br8m_pkg;

    localparam int ProductWidth = 32;

    typedef enum logic [2:0] {
        MAG_ZERO,
        MAG_ONE,
        MAG_TWO,
        MAG_THREE,
        MAG_FOUR
    } booth_mag_t;

    typedef struct packed {
        logic       neg;
        booth_mag_t mag;
    } booth_digit_t;

    // Digit table: groups 0..15 map to 0,1,1,2,2,3,3,4,-4,-3,-3,-2,-2,-1,-1,0
    function automatic booth_digit_t booth_digit(input logic [3:0] grp);
        booth_digit_t d;
        d.neg = grp[3] & ~(&grp[2:0]);
        case (grp) inside
            4'd1, 4'd2, 4'd13, 4'd14:  d.mag = MAG_ONE;
            4'd3, 4'd4, 4'd11, 4'd12:  d.mag = MAG_TWO;
            4'd5, 4'd6, 4'd9, 4'd10:   d.mag = MAG_THREE;
            4'd7, 4'd8:                d.mag = MAG_FOUR;
            default:                   d.mag = MAG_ZERO;
        endcase
        return d;
    endfunction

endpackage

// ----- src/br8m_recode.sv -----
// Stage one: Booth recoding of the multiplier and the 3y precompute.
module br8m_recode
    import br8m_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [OPERAND_WIDTH-1:0]               multiplier,
    input  logic [OPERAND_WIDTH-1:0]               multiplicand,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [OPERAND_WIDTH-1:0]               y_out,
    output logic [OPERAND_WIDTH+1:0]               y3_out,
    output booth_digit_t [(OPERAND_WIDTH+2)/3-1:0] digits_out
);

    localparam int GroupCount = (OPERAND_WIDTH + 2) / 3;
    localparam int ExtWidth   = 3 * GroupCount + 3;

    logic                              valid_reg;
    logic [OPERAND_WIDTH-1:0]          y_reg;
    logic [OPERAND_WIDTH+1:0]          y3_reg;
    logic [OPERAND_WIDTH+1:0]          y3_next;
    booth_digit_t [GroupCount-1:0]     digit_reg;
    booth_digit_t [GroupCount-1:0]     digit_next;
    logic [ExtWidth-1:0]               x_ext;

    assign in_ready = !valid_reg || out_ready;

    // Repeat the sign above the top bit and put a zero below bit 0
    assign x_ext = {{(ExtWidth - OPERAND_WIDTH - 1){multiplier[OPERAND_WIDTH-1]}},
                    multiplier, 1'b0};

    assign y3_next = {{2{multiplicand[OPERAND_WIDTH-1]}}, multiplicand}
                   + {multiplicand[OPERAND_WIDTH-1], multiplicand, 1'b0};

    always_comb
    begin
        for (int i = 0; i < GroupCount; i++)
        begin
            digit_next[i] = booth_digit(x_ext[3*i +: 4]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            y_reg     <= multiplicand;
            y3_reg    <= y3_next;
            digit_reg <= digit_next;
        end
    end

    assign out_valid  = valid_reg;
    assign y_out      = y_reg;
    assign y3_out     = y3_reg;
    assign digits_out = digit_reg;

endmodule

// ----- src/br8m_ppgen.sv -----
// Stage two: partial product selection, negation and weighting.
module br8m_ppgen
    import br8m_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [OPERAND_WIDTH-1:0]                 y_in,
    input  logic [OPERAND_WIDTH+1:0]                 y3_in,
    input  booth_digit_t [(OPERAND_WIDTH+2)/3-1:0]   digits_in,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [(OPERAND_WIDTH+2)/3-1:0][2*OPERAND_WIDTH-1:0] pp_out
);

    localparam int GroupCount = (OPERAND_WIDTH + 2) / 3;
    localparam int PpWidth    = 2 * OPERAND_WIDTH;

    logic                                 valid_reg;
    logic [GroupCount-1:0][PpWidth-1:0]   pp_reg;
    logic [GroupCount-1:0][PpWidth-1:0]   pp_next;
    logic [PpWidth-1:0]                   y_ext;
    logic [PpWidth-1:0]                   y3_ext;

    assign in_ready = !valid_reg || out_ready;

    assign y_ext  = PpWidth'($signed(y_in));
    assign y3_ext = PpWidth'($signed(y3_in));

    always_comb
    begin
        logic [PpWidth-1:0] mult;
        for (int i = 0; i < GroupCount; i++)
        begin
            case (digits_in[i].mag)
                MAG_ONE:   mult = y_ext;
                MAG_TWO:   mult = y_ext << 1;
                MAG_THREE: mult = y3_ext;
                MAG_FOUR:  mult = y_ext << 2;
                default:   mult = '0;
            endcase
            if (digits_in[i].neg)
            begin
                mult = ~mult + PpWidth'(1);
            end
            pp_next[i] = mult << (3 * i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pp_reg <= pp_next;
        end
    end

    assign out_valid = valid_reg;
    assign pp_out    = pp_reg;

endmodule

// ----- src/br8m_sum.sv -----
// Stages three and four: half sums of the partial products, then the final add.
module br8m_sum
    import br8m_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                in_valid,
    output logic                                                in_ready,
    input  logic [(OPERAND_WIDTH+2)/3-1:0][2*OPERAND_WIDTH-1:0] pp_in,
    output logic                                                out_valid,
    input  logic                                                out_ready,
    output logic [ProductWidth-1:0]                             product
);

    localparam int GroupCount = (OPERAND_WIDTH + 2) / 3;
    localparam int PpWidth    = 2 * OPERAND_WIDTH;
    localparam int HalfCount  = GroupCount / 2;

    logic                     half_valid_reg;
    logic [PpWidth-1:0]       lo_reg;
    logic [PpWidth-1:0]       hi_reg;
    logic [PpWidth-1:0]       lo_next;
    logic [PpWidth-1:0]       hi_next;
    logic                     final_ready;
    logic                     out_valid_reg;
    logic [ProductWidth-1:0]  product_reg;
    logic [ProductWidth-1:0]  product_next;
    logic [PpWidth-1:0]       total;

    assign final_ready = !out_valid_reg || out_ready;
    assign in_ready    = !half_valid_reg || final_ready;

    always_comb
    begin
        lo_next = '0;
        hi_next = '0;
        for (int i = 0; i < GroupCount; i++)
        begin
            if (i < HalfCount)
            begin
                lo_next = lo_next + pp_in[i];
            end
            else
            begin
                hi_next = hi_next + pp_in[i];
            end
        end
    end

    // Sign-extend or wrap the product to the output width
    assign total        = lo_reg + hi_reg;
    assign product_next = ProductWidth'($signed(total));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                half_valid_reg <= in_valid;
            end
            if (final_ready)
            begin
                out_valid_reg <= half_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (final_ready && half_valid_reg)
        begin
            product_reg <= product_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = product_reg;

    // Hold the half sums while the final stage is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (half_valid_reg && !final_ready) |=>
            (half_valid_reg && $stable(lo_reg) && $stable(hi_reg)))
        else $error("half sums changed while blocked");

endmodule

// ----- src/booth_radix8_multiplier_core.sv -----
// Top level of the pipelined signed radix-8 Booth multiplier.
// From input transfer to result the data passes recode, partial products,
// half sums and final add, each stage a register with its own valid bit.
// Throughput: one operand pair per cycle; a stalled output holds the full stages
// while empty stages still fill, and s_tready drops only when all four are full.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers keep garbage.
module booth_radix8_multiplier_core
    import br8m_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // fields from bit 0: multiplier, multiplicand, zero fill to whole bytes
    input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]  s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // fields from bit 0: product
    output logic [ProductWidth-1:0]               m_tdata
);

    localparam int GroupCount = (OPERAND_WIDTH + 2) / 3;

    logic                                          rc_valid;
    logic                                          pg_ready;
    logic [OPERAND_WIDTH-1:0]                      rc_y;
    logic [OPERAND_WIDTH+1:0]                      rc_y3;
    booth_digit_t [GroupCount-1:0]                 rc_digits;
    logic                                          pg_valid;
    logic                                          sm_ready;
    logic [GroupCount-1:0][2*OPERAND_WIDTH-1:0]    pg_pp;

    br8m_recode #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_recode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .multiplier   (s_tdata[OPERAND_WIDTH-1:0]),
        .multiplicand (s_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH]),
        .out_valid    (rc_valid),
        .out_ready    (pg_ready),
        .y_out        (rc_y),
        .y3_out       (rc_y3),
        .digits_out   (rc_digits)
    );

    br8m_ppgen #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_ppgen (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rc_valid),
        .in_ready  (pg_ready),
        .y_in      (rc_y),
        .y3_in     (rc_y3),
        .digits_in (rc_digits),
        .out_valid (pg_valid),
        .out_ready (sm_ready),
        .pp_out    (pg_pp)
    );

    br8m_sum #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pg_valid),
        .in_ready  (sm_ready),
        .pp_in     (pg_pp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .product   (m_tdata)
    );

    // Back-pressure at the input only when a result waits at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input blocked without a stalled result");

    // With the output draining, a transfer reaches the output after four stages
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

    // The recode stage is blocked only when the partial product stage after it is full and blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (rc_valid && !pg_ready) |-> (pg_valid && !sm_ready))
        else $error("recode stage blocked by a draining stage");

endmodule
